/* rtl/integer_range_list_matcher_macros.svh */
// ----------------------------------------------------------------------------
// integer_range_list_matcher_macros.svh
// Assertion macros shared by the range list matcher RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_RANGE_LIST_MATCHER_MACROS_SVH
`define INTEGER_RANGE_LIST_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Checks that cond implies prop in the same cycle.
`define IRLM_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Checks that cond implies prop in the next cycle.
`define IRLM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define IRLM_ASSERT_SAME(label, clk, rst_n, cond, prop, msg)
`define IRLM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

/* rtl/irlm_pkg.sv */
// ----------------------------------------------------------------------------
// irlm_pkg
// Types, codes and helper functions of the integer range list matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irlm_pkg;

    localparam int MAX_RANGES_DEF = 16;

    // Request kinds.
    localparam logic [1:0] REQ_CHAR  = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Outcome of a range that was closed or added.
    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_ADDED    = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS,
        PH_DONE
    } number_phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } number_base_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         char_code;
        logic               last_char;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic signed [31:0] query_id;
    } req_t;

    typedef struct packed {
        logic       matched;
        logic [1:0] add_status;
        logic [4:0] ranges_held;
    } res_t;

    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
    } range_entry_t;

    // Returns {valid, value} for a hexadecimal digit character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Returns {valid, value} of c read as a digit in the given base.
    function automatic logic [4:0] base_digit(input logic [7:0] c, input number_base_t b);
        logic [4:0] h;
        logic [4:0] r;
        h = hex_digit(c);
        r = h;
        unique case (b)
            BASE_OCT: r[4] = h[4] && (h[3:0] < 4'd8);
            BASE_DEC: r[4] = h[4] && (h[3:0] < 4'd10);
            default:  r[4] = h[4];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/integer_range_list_matcher.sv */
// A text character or a direct add gives its result in the cycle after acceptance.
// A match query scans one stored range per cycle through the range memory read port
// and stops at the first hit or the last stored range; on an empty table it does not scan.
// One character or add is taken per cycle while idle; busy stays high while a query scans.
// Reset (rst_n, asynchronous) empties the table and the text reader; memory is not cleared.
// The receiver cannot stall: each result is shown for one cycle with done high.
// ----------------------------------------------------------------------------
// integer_range_list_matcher
// Range table fed by range list text or direct adds, with membership queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_range_list_matcher_macros.svh"

module integer_range_list_matcher #(
    parameter int MAX_RANGES = irlm_pkg::MAX_RANGES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire irlm_pkg::req_t req,
    output logic               busy,
    output logic               done,
    output irlm_pkg::res_t     result
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    // Range memory, one entry per stored range.
    irlm_pkg::range_entry_t mem [MAX_RANGES];
    irlm_pkg::range_entry_t rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;

    irlm_pkg::scan_state_t   state_reg, state_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic signed [31:0]      query_reg, query_next;
    logic [31:0]             first_reg, first_next;
    logic                    slot_reg, slot_next;
    logic                    nonempty_reg, nonempty_next;
    irlm_pkg::number_phase_t phase_reg, phase_next;
    irlm_pkg::number_base_t  base_reg, base_next;
    logic [31:0]             value_reg, value_next;
    logic                    done_reg, done_next;
    irlm_pkg::res_t          result_reg, result_next;

    logic              accept;
    logic              blank;
    logic              first_char;
    logic [4:0]        dig;
    logic [4:0]        hdig;
    logic [35:0]       scaled;
    logic [35:0]       acc;
    logic              store_req;
    logic signed [31:0] store_lo;
    logic signed [31:0] store_hi;
    logic [1:0]        status;
    logic              hit;
    logic              scan_last;
    logic [4:0]        held_ext;

    assign accept = start && !busy;
    assign busy   = (state_reg == irlm_pkg::ST_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

    assign blank = (req.char_code == irlm_pkg::CHAR_SPACE) ||
                   (req.char_code >= irlm_pkg::CHAR_TAB && req.char_code <= irlm_pkg::CHAR_CR);
    assign dig   = irlm_pkg::base_digit(req.char_code, base_reg);
    assign hdig  = irlm_pkg::hex_digit(req.char_code);

    // Next digit step of the number being read; overflow saturates the value at all ones.
    always_comb
    begin
        unique case (base_reg)
            irlm_pkg::BASE_HEX: scaled = {value_reg, 4'b0000};
            irlm_pkg::BASE_OCT: scaled = {1'b0, value_reg, 3'b000};
            default:            scaled = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0};
        endcase
        acc = scaled + {32'd0, dig[3:0]};
    end

    assign hit = (query_reg >= rd_data_reg.low) && (rd_data_reg.high >= query_reg);
    assign scan_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == used_reg);

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        ptr_next      = ptr_reg;
        query_next    = query_reg;
        first_next    = first_reg;
        slot_next     = slot_reg;
        nonempty_next = nonempty_reg;
        phase_next    = phase_reg;
        base_next     = base_reg;
        value_next    = value_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        store_req     = 1'b0;
        store_lo      = 32'sd0;
        store_hi      = 32'sd0;
        status        = irlm_pkg::STAT_NONE;
        first_char    = 1'b0;
        wr_en         = 1'b0;
        rd_addr       = '0;

        unique case (state_reg)
            irlm_pkg::ST_IDLE:
            begin
                if (accept) begin
                    done_next = 1'b1;
                    case (req.req_type)
                        irlm_pkg::REQ_CHAR:
                        begin
                            if (req.char_code == irlm_pkg::CHAR_COMMA) begin
                                if (nonempty_reg) begin
                                    store_req = 1'b1;
                                    store_hi  = $signed(value_reg);
                                    store_lo  = slot_reg ? $signed(first_reg)
                                                         : $signed(value_reg);
                                    slot_next = 1'b0;
                                end
                            end else if (req.char_code == irlm_pkg::CHAR_DASH) begin
                                if (nonempty_reg && !slot_reg) begin
                                    first_next = value_reg;
                                    slot_next  = 1'b1;
                                end
                            end else begin
                                nonempty_next = 1'b1;
                                case (phase_reg)
                                    irlm_pkg::PH_START:
                                    begin
                                        if (!blank) begin
                                            if (req.char_code == irlm_pkg::CHAR_PLUS) begin
                                                phase_next = irlm_pkg::PH_SIGN;
                                            end else begin
                                                first_char = 1'b1;
                                            end
                                        end
                                    end
                                    irlm_pkg::PH_SIGN:
                                    begin
                                        first_char = 1'b1;
                                    end
                                    irlm_pkg::PH_ZERO:
                                    begin
                                        if (req.char_code == irlm_pkg::CHAR_LOW_X ||
                                            req.char_code == irlm_pkg::CHAR_UP_X) begin
                                            phase_next = irlm_pkg::PH_HEXPFX;
                                        end else if (hdig[4] && hdig[3:0] < 4'd8) begin
                                            base_next  = irlm_pkg::BASE_OCT;
                                            value_next = {28'd0, hdig[3:0]};
                                            phase_next = irlm_pkg::PH_DIGITS;
                                        end else begin
                                            phase_next = irlm_pkg::PH_DONE;
                                        end
                                    end
                                    irlm_pkg::PH_HEXPFX:
                                    begin
                                        if (hdig[4]) begin
                                            base_next  = irlm_pkg::BASE_HEX;
                                            value_next = {28'd0, hdig[3:0]};
                                            phase_next = irlm_pkg::PH_DIGITS;
                                        end else begin
                                            phase_next = irlm_pkg::PH_DONE;
                                        end
                                    end
                                    irlm_pkg::PH_DIGITS:
                                    begin
                                        if (dig[4]) begin
                                            value_next = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                                : acc[31:0];
                                        end else begin
                                            phase_next = irlm_pkg::PH_DONE;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase

                                // First significant character of a number.
                                if (first_char) begin
                                    if (req.char_code == irlm_pkg::CHAR_ZERO) begin
                                        phase_next = irlm_pkg::PH_ZERO;
                                    end else if (req.char_code > irlm_pkg::CHAR_ZERO &&
                                                 req.char_code <= irlm_pkg::CHAR_NINE) begin
                                        base_next  = irlm_pkg::BASE_DEC;
                                        value_next = {28'd0, hdig[3:0]};
                                        phase_next = irlm_pkg::PH_DIGITS;
                                    end else begin
                                        phase_next = irlm_pkg::PH_DONE;
                                    end
                                end

                                if (req.last_char) begin
                                    store_req = 1'b1;
                                    store_hi  = $signed(value_next);
                                    store_lo  = slot_reg ? $signed(first_reg)
                                                         : $signed(value_next);
                                end
                            end

                            // Delimiters and the end of the text clear the token.
                            if (req.char_code == irlm_pkg::CHAR_COMMA ||
                                req.char_code == irlm_pkg::CHAR_DASH || req.last_char) begin
                                nonempty_next = 1'b0;
                                phase_next    = irlm_pkg::PH_START;
                                base_next     = irlm_pkg::BASE_DEC;
                                value_next    = 32'd0;
                            end
                            if (req.last_char) begin
                                slot_next = 1'b0;
                            end
                        end
                        irlm_pkg::REQ_ADD:
                        begin
                            store_req = 1'b1;
                            store_lo  = req.range_low;
                            store_hi  = req.range_high;
                        end
                        irlm_pkg::REQ_QUERY:
                        begin
                            query_next = req.query_id;
                            ptr_next   = '0;
                            if (used_reg != '0) begin
                                done_next  = 1'b0;
                                state_next = irlm_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (store_req) begin
                        if (store_hi < store_lo) begin
                            status = irlm_pkg::STAT_REJECTED;
                        end else if (used_reg == CNT_W'(MAX_RANGES)) begin
                            status = irlm_pkg::STAT_FULL;
                        end else begin
                            status    = irlm_pkg::STAT_ADDED;
                            wr_en     = 1'b1;
                            used_next = used_reg + CNT_W'(1);
                        end
                    end

                    result_next.matched     = 1'b0;
                    result_next.add_status  = status;
                    result_next.ranges_held = held_ext;
                end
            end
            irlm_pkg::ST_SCAN:
            begin
                // Read data belongs to ptr_reg; the next entry is fetched meanwhile.
                rd_addr = ptr_reg + IDX_W'(1);
                if (hit || scan_last) begin
                    done_next               = 1'b1;
                    state_next              = irlm_pkg::ST_IDLE;
                    result_next.matched     = hit;
                    result_next.add_status  = irlm_pkg::STAT_NONE;
                    result_next.ranges_held = held_ext;
                end else begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = irlm_pkg::ST_IDLE;
            end
        endcase
    end

    assign held_ext = 5'(used_next);

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[used_reg[IDX_W-1:0]] <= '{low: store_lo, high: store_hi};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= irlm_pkg::ST_IDLE;
            used_reg     <= '0;
            first_reg    <= 32'd0;
            slot_reg     <= 1'b0;
            nonempty_reg <= 1'b0;
            phase_reg    <= irlm_pkg::PH_START;
            base_reg     <= irlm_pkg::BASE_DEC;
            value_reg    <= 32'd0;
            done_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            first_reg    <= first_next;
            slot_reg     <= slot_next;
            nonempty_reg <= nonempty_next;
            phase_reg    <= phase_next;
            base_reg     <= base_next;
            value_reg    <= value_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        query_reg  <= query_next;
        result_reg <= result_next;
    end

    `IRLM_ASSERT_SAME(a_no_result_while_scanning, clk, rst_n, state_reg == irlm_pkg::ST_SCAN, !done_reg, "result strobe during a scan")
    `IRLM_ASSERT_SAME(a_count_in_range, clk, rst_n, 1'b1, used_reg <= CNT_W'(MAX_RANGES), "range count beyond table size")
    `IRLM_ASSERT_NEXT(a_query_progress, clk, rst_n, accept && req.req_type == irlm_pkg::REQ_QUERY, busy || done_reg, "query neither scanned nor answered")
    `IRLM_ASSERT_SAME(a_scan_inside_table, clk, rst_n, state_reg == irlm_pkg::ST_SCAN, CNT_W'(ptr_reg) < used_reg, "scan pointer past stored ranges")

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range list matcher. A short table of directed
// requests covers the extremes and the odd cases of the list text reader;
// random list texts, direct adds and match queries follow, under several
// patterns of sender idling. Every result is compared field by field with a
// prediction kept by the bench itself, or with the result pinned to a directed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int TBL_DEPTH = irlm_pkg::MAX_RANGES_DEF;
    localparam int ITEMS_PER_PHASE = 400;

    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [7:0] CH_A_LOW = 8'h61;
    localparam logic [7:0] CH_F_LOW = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic signed [31:0] INT_LO = 32'sh8000_0000;
    localparam logic signed [31:0] INT_HI = 32'sh7FFF_FFFF;

    typedef struct {
        irlm_pkg::req_t r;
        bit             pinned;
        irlm_pkg::res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    irlm_pkg::req_t req = '0;
    logic busy;
    logic done;
    irlm_pkg::res_t result;

    // A directed row may carry its expected result; it travels with the request.
    logic pinned_valid = 1'b0;
    irlm_pkg::res_t pinned_res = '0;

    // Predicted contents of the range table and the text reader.
    logic signed [31:0]      tbl_low [TBL_DEPTH];
    logic signed [31:0]      tbl_high [TBL_DEPTH];
    int                      tbl_count = 0;
    logic [31:0]             pend_low = '0;
    logic                    pend_open = 1'b0;
    logic                    tok_seen = 1'b0;
    irlm_pkg::number_phase_t tok_phase = irlm_pkg::PH_START;
    irlm_pkg::number_base_t  tok_base = irlm_pkg::BASE_DEC;
    logic [31:0]             tok_value = '0;

    irlm_pkg::res_t due_results [$];
    stim_row_t      directed_rows [$];
    logic [7:0]     list_text [$];
    int             mismatches = 0;
    int             sent_count = 0;
    int             idle_pct = 0;

    integer_range_list_matcher #(
        .MAX_RANGES(TBL_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_token();
        tok_seen = 1'b0;
        tok_phase = irlm_pkg::PH_START;
        tok_base = irlm_pkg::BASE_DEC;
        tok_value = '0;
    endfunction

    function automatic int digit_in(logic [7:0] c, irlm_pkg::number_base_t b);
        int d;
        d = -1;
        if (c >= irlm_pkg::CHAR_ZERO && c <= irlm_pkg::CHAR_NINE) begin
            d = int'(c - irlm_pkg::CHAR_ZERO);
        end else if (c >= CH_A_LOW && c <= CH_F_LOW) begin
            d = int'(c - CH_A_LOW) + 10;
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            d = int'(c - CH_A_UP) + 10;
        end
        if (d < 0) return -1;
        if (b == irlm_pkg::BASE_OCT && d >= 8) return -1;
        if (b == irlm_pkg::BASE_DEC && d >= 10) return -1;
        return d;
    endfunction

    function automatic void accumulate(int d);
        logic [63:0] v;
        int          mul;
        mul = (tok_base == irlm_pkg::BASE_HEX) ? 16 :
              ((tok_base == irlm_pkg::BASE_OCT) ? 8 : 10);
        v = 64'(tok_value) * 64'(mul) + 64'(d);
        tok_value = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void feed_char(logic [7:0] c);
        logic blank;
        int   d;
        blank = (c == irlm_pkg::CHAR_SPACE) ||
                (c >= irlm_pkg::CHAR_TAB && c <= irlm_pkg::CHAR_CR);
        if (tok_phase == irlm_pkg::PH_START) begin
            if (blank) return;
            if (c == irlm_pkg::CHAR_PLUS) begin
                tok_phase = irlm_pkg::PH_SIGN;
                return;
            end
        end
        case (tok_phase) inside
            irlm_pkg::PH_START, irlm_pkg::PH_SIGN:
            begin
                if (c == irlm_pkg::CHAR_ZERO) begin
                    tok_phase = irlm_pkg::PH_ZERO;
                end else if (c > irlm_pkg::CHAR_ZERO && c <= irlm_pkg::CHAR_NINE) begin
                    tok_base = irlm_pkg::BASE_DEC;
                    tok_value = 32'(c - irlm_pkg::CHAR_ZERO);
                    tok_phase = irlm_pkg::PH_DIGITS;
                end else begin
                    tok_phase = irlm_pkg::PH_DONE;
                end
            end
            irlm_pkg::PH_ZERO:
            begin
                d = digit_in(c, irlm_pkg::BASE_OCT);
                if (c == irlm_pkg::CHAR_LOW_X || c == irlm_pkg::CHAR_UP_X) begin
                    tok_phase = irlm_pkg::PH_HEXPFX;
                end else if (d >= 0) begin
                    tok_base = irlm_pkg::BASE_OCT;
                    tok_value = 32'(d);
                    tok_phase = irlm_pkg::PH_DIGITS;
                end else begin
                    tok_phase = irlm_pkg::PH_DONE;
                end
            end
            irlm_pkg::PH_HEXPFX:
            begin
                d = digit_in(c, irlm_pkg::BASE_HEX);
                if (d >= 0) begin
                    tok_base = irlm_pkg::BASE_HEX;
                    tok_value = 32'(d);
                    tok_phase = irlm_pkg::PH_DIGITS;
                end else begin
                    tok_phase = irlm_pkg::PH_DONE;
                end
            end
            irlm_pkg::PH_DIGITS:
            begin
                d = digit_in(c, tok_base);
                if (d >= 0) accumulate(d);
                else tok_phase = irlm_pkg::PH_DONE;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [1:0] store_range(logic signed [31:0] lo,
                                               logic signed [31:0] hi);
        if (hi < lo) return irlm_pkg::STAT_REJECTED;
        if (tbl_count >= TBL_DEPTH) return irlm_pkg::STAT_FULL;
        tbl_low[tbl_count] = lo;
        tbl_high[tbl_count] = hi;
        tbl_count++;
        return irlm_pkg::STAT_ADDED;
    endfunction

    // A nonempty token ends a range: from the bound before the dash if there
    // was one, otherwise a range of the single value.
    function automatic logic [1:0] close_token();
        logic [1:0] st;
        st = store_range(pend_open ? pend_low : tok_value, tok_value);
        pend_open = 1'b0;
        clear_token();
        return st;
    endfunction

    function automatic irlm_pkg::res_t apply_request(irlm_pkg::req_t r);
        irlm_pkg::res_t o;
        int             i;
        o = '0;
        if (r.req_type == irlm_pkg::REQ_CHAR) begin
            if (r.char_code == irlm_pkg::CHAR_COMMA) begin
                // An empty token keeps a pending bound from an earlier dash.
                if (tok_seen) o.add_status = close_token();
                clear_token();
            end else if (r.char_code == irlm_pkg::CHAR_DASH) begin
                if (tok_seen && !pend_open) begin
                    pend_low = tok_value;
                    pend_open = 1'b1;
                end
                clear_token();
            end else begin
                tok_seen = 1'b1;
                feed_char(r.char_code);
                if (r.last_char) o.add_status = close_token();
            end
            if (r.last_char) begin
                pend_open = 1'b0;
                clear_token();
            end
        end else if (r.req_type == irlm_pkg::REQ_ADD) begin
            o.add_status = store_range(r.range_low, r.range_high);
        end else if (r.req_type == irlm_pkg::REQ_QUERY) begin
            for (i = 0; i < tbl_count; i++) begin
                if (r.query_id >= tbl_low[i] && r.query_id <= tbl_high[i]) o.matched = 1'b1;
            end
        end
        o.ranges_held = tbl_count[4:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watch_results
        irlm_pkg::res_t want;
        irlm_pkg::res_t calc;
        if (rst_n) begin
            if (done) begin
                if (due_results.size() == 0) begin
                    report($sformatf("result %h with none expected", result));
                end else begin
                    want = due_results.pop_front();
                    if (result.matched !== want.matched)
                        report($sformatf("matched got %b, expected %b",
                                         result.matched, want.matched));
                    if (result.add_status !== want.add_status)
                        report($sformatf("add_status got %0d, expected %0d",
                                         result.add_status, want.add_status));
                    if (result.ranges_held !== want.ranges_held)
                        report($sformatf("ranges_held got %0d, expected %0d",
                                         result.ranges_held, want.ranges_held));
                end
            end
            if (start && !busy) begin
                calc = apply_request(req);
                due_results.push_back(pinned_valid ? pinned_res : calc);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic irlm_pkg::req_t mk_req(logic [1:0] t, logic [7:0] c, logic l,
                                              logic [31:0] lo, logic [31:0] hi,
                                              logic [31:0] q);
        irlm_pkg::req_t r;
        r.req_type = t;
        r.char_code = c;
        r.last_char = l;
        r.range_low = lo;
        r.range_high = hi;
        r.query_id = q;
        return r;
    endfunction

    function automatic void dir_row(irlm_pkg::req_t r, bit pinned, irlm_pkg::res_t want);
        stim_row_t row;
        row.r = r;
        row.pinned = pinned;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void push_str(string s);
        int k;
        for (k = 0; k < s.len(); k++) list_text.push_back(s[k]);
    endfunction

    // One token of list text: optional blank and sign, a number in some base
    // or form, and now and then a stray character after it.
    function automatic void push_token();
        int         kind;
        logic [7:0] b;
        string      s;
        kind = $urandom_range(11);
        s = "";
        if ($urandom_range(3) == 0) begin
            b = 8'($urandom_range(8, 13));
            if (b == 8'd8) b = irlm_pkg::CHAR_SPACE;
            list_text.push_back(b);
        end
        if ($urandom_range(3) == 0) list_text.push_back(irlm_pkg::CHAR_PLUS);
        case (kind) inside
            1, 2, 3: s = $sformatf("%0d", $urandom_range(300));
            4:       s = $sformatf("%0d", $urandom);
            // Eleven digits or more always saturate.
            5:       s = $sformatf("%0d%010d", $urandom_range(1, 9), $urandom);
            6, 7:
            begin
                s = $sformatf("0x%0h", $urandom_range(1) ? $urandom_range(255) : $urandom);
                if ($urandom_range(1)) s = s.toupper();
            end
            8:       s = $sformatf("0x%0h%08h", $urandom_range(1, 15), $urandom);
            9:       s = $sformatf("0%0o", $urandom_range(511));
            10:      s = $urandom_range(1) ? "0x" : $sformatf("0%0d", $urandom_range(8, 9));
            default: s = "";
        endcase
        push_str(s);
        if (kind == 11 || $urandom_range(4) == 0) list_text.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_list();
        int n_ranges;
        int k;
        list_text.delete();
        n_ranges = $urandom_range(1, 3);
        for (k = 0; k < n_ranges; k++) begin
            if (k != 0) list_text.push_back(irlm_pkg::CHAR_COMMA);
            push_token();
            if ($urandom_range(9) < 6) begin
                list_text.push_back(irlm_pkg::CHAR_DASH);
                push_token();
            end
            if ($urandom_range(9) == 0) begin
                list_text.push_back(irlm_pkg::CHAR_DASH);
                push_token();
            end
        end
        if ($urandom_range(4) == 0) list_text.push_back(irlm_pkg::CHAR_COMMA);
        if (list_text.size() == 0) list_text.push_back(irlm_pkg::CHAR_NINE);
    endfunction

    function automatic logic [31:0] pick_query();
        int i;
        if (tbl_count == 0 || $urandom_range(9) == 0) return $urandom;
        i = $urandom_range(tbl_count - 1);
        case ($urandom_range(5))
            0:       return tbl_low[i];
            1:       return tbl_high[i];
            2:       return tbl_low[i] - 1;
            3:       return tbl_high[i] + 1;
            4:       return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic pause_sender(bit drain, int cycles);
        start <= 1'b0;
        if (drain) begin
            @(posedge clk);
            while (due_results.size() != 0) @(posedge clk);
        end else begin
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Presents one request, returns once it is taken and busy is low, and may then idle the sender.
    task automatic send_request(irlm_pkg::req_t r, bit pinned, irlm_pkg::res_t want);
        start <= 1'b1;
        req <= r;
        pinned_valid <= pinned;
        pinned_res <= want;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (r.req_type != REQ_RESERVED) sent_count++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            pause_sender(1'b0, $urandom_range(1, ($urandom_range(3) == 0) ? 20 : 3));
    endtask

    task automatic issue_random_item();
        int                 pick;
        int                 k;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        pick = $urandom_range(99);
        if (pick < 40) begin
            build_list();
            for (k = 0; k < list_text.size(); k++)
                send_request(mk_req(irlm_pkg::REQ_CHAR, list_text[k],
                                    k == list_text.size() - 1,
                                    $urandom, $urandom, $urandom), 1'b0, '0);
        end else if (pick < 55) begin
            if ($urandom_range(3) == 0) begin
                lo = $urandom;
                hi = $urandom;
            end else begin
                lo = $urandom_range(2000) - 1000;
                hi = lo + $urandom_range(60) - 10;
            end
            send_request(mk_req(irlm_pkg::REQ_ADD, 8'($urandom), 1'($urandom), lo, hi,
                                $urandom), 1'b0, '0);
        end else if (pick < 93) begin
            send_request(mk_req(irlm_pkg::REQ_QUERY, 8'($urandom), 1'($urandom), $urandom,
                                $urandom, pick_query()), 1'b0, '0);
        end else begin
            case ($urandom_range(2))
                0: send_request(mk_req(REQ_RESERVED, 8'($urandom), 1'($urandom), $urandom,
                                       $urandom, $urandom), 1'b0, '0);
                1: send_request(mk_req(irlm_pkg::REQ_CHAR, 8'($urandom), 1'($urandom),
                                       $urandom, $urandom, $urandom), 1'b0, '0);
                default: send_request(mk_req(2'($urandom_range(irlm_pkg::REQ_ADD,
                                                               irlm_pkg::REQ_QUERY)),
                                             8'($urandom), 1'b1, $urandom,
                                             $urandom, $urandom), 1'b0, '0);
            endcase
        end
    endtask

    initial
    begin
        int    idle_plan [4];
        int    ph;
        int    k;
        string text;
        idle_plan = '{0, 64, 0, 17};
        text = " +0xF-017-9,,";

        // Nothing matches on an empty table.
        dir_row(mk_req(irlm_pkg::REQ_QUERY, 8'h00, 1'b0, 0, 0, 0), 1'b1,
                irlm_pkg::res_t'{1'b0, irlm_pkg::STAT_NONE, 5'd0});
        dir_row(mk_req(irlm_pkg::REQ_ADD, 8'h00, 1'b0, INT_LO, INT_HI, 0), 1'b1,
                irlm_pkg::res_t'{1'b0, irlm_pkg::STAT_ADDED, 5'd1});
        dir_row(mk_req(irlm_pkg::REQ_ADD, 8'h00, 1'b0, 5, 4, 0), 1'b1,
                irlm_pkg::res_t'{1'b0, irlm_pkg::STAT_REJECTED, 5'd1});
        dir_row(mk_req(irlm_pkg::REQ_QUERY, 8'h00, 1'b0, 0, 0, INT_LO), 1'b1,
                irlm_pkg::res_t'{1'b1, irlm_pkg::STAT_NONE, 5'd1});
        // The unused request kind changes nothing.
        dir_row(mk_req(REQ_RESERVED, 8'hFF, 1'b1, '1, '1, '1), 1'b1,
                irlm_pkg::res_t'{1'b0, irlm_pkg::STAT_NONE, 5'd1});
        dir_row(mk_req(irlm_pkg::REQ_QUERY, 8'hFF, 1'b1, 0, 0, INT_HI), 1'b1,
                irlm_pkg::res_t'{1'b1, irlm_pkg::STAT_NONE, 5'd1});
        // Blank, sign, hex, octal, a dash in the second slot, then an empty token.
        for (k = 0; k < text.len(); k++)
            dir_row(mk_req(irlm_pkg::REQ_CHAR, text[k], 1'b0, 0, 0, 0), 1'b0, '0);
        // A lone NUL ends the text and closes a range of zero.
        dir_row(mk_req(irlm_pkg::REQ_CHAR, CH_NUL, 1'b1, 0, 0, 0), 1'b1,
                irlm_pkg::res_t'{1'b0, irlm_pkg::STAT_ADDED, 5'd2});
        dir_row(mk_req(irlm_pkg::REQ_ADD, 8'h00, 1'b0, INT_HI, INT_HI, 0), 1'b0, '0);
        dir_row(mk_req(irlm_pkg::REQ_QUERY, 8'h00, 1'b0, 0, 0, '1), 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].r, directed_rows[i].pinned, directed_rows[i].want);
        pause_sender(1'b1, 0);

        for (ph = 0; ph < 4; ph++) begin
            idle_pct = idle_plan[ph];
            while (sent_count < (ph + 1) * ITEMS_PER_PHASE) issue_random_item();
            pause_sender(1'b1, 0);
        end

        repeat (TBL_DEPTH + 4) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/irlm_pkg.sv
rtl/integer_range_list_matcher.sv
tb/tb.sv
